[design/assert_macros.svh]
// Assertion macros for the checker file of the note and bank tracker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, muted while reset is low
`define MONT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition never holds on a clock edge outside reset
`define MONT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `MONT_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

[design/mont_pkg.sv]
// Types and fixed constants for the MIDI output note and bank tracker.
// No dependencies; imported by the top level and its checker.
package mont_pkg;

  // One input transaction
  typedef struct packed {
    logic              func;
    logic [7:0]        status;
    logic [6:0]        data_a;
    logic [6:0]        data_b;
    logic signed [7:0] bank_lsb;
    logic signed [7:0] bank_msb;
    logic signed [7:0] program_req;
  } in_t;

  // One emitted MIDI message
  typedef struct packed {
    logic [7:0] out_status;
    logic [6:0] out_data_a;
    logic [6:0] out_data_b;
    logic       last;
  } out_t;

  localparam int CNT_W       = 6;   // held-note count width
  localparam int CH_W        = 4;   // channel nibble
  localparam int BANK_DEPTH  = 16;  // bank and program tables, one per channel nibble
  localparam int ADDR_FULL_W = 11;  // channel * notes + note before trimming

  // Status high nibbles
  localparam logic [3:0] SN_NOTE_OFF = 4'h8;
  localparam logic [3:0] SN_CTRL     = 4'hB;
  localparam logic [3:0] SN_PROG     = 4'hC;
  localparam logic [3:0] SN_SYSTEM   = 4'hF;

  // Controller numbers for bank select
  localparam logic [6:0] CC_BANK_MSB = 7'd0;
  localparam logic [6:0] CC_BANK_LSB = 7'd32;

endpackage

[design/mont_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the held-note count store.
module mont_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/midi_out_note_and_bank_tracker.sv]
// Channel  | Direction | Handshake                 | Payload
// request  | in        | start_i high, busy_o low  | req_i (in_t)
// result   | out       | res_valid_o, one cycle    | res_o (out_t)
//
// A send passes a plan state, then an emit state sends its messages; a flush sends one
// note-off per held count. Results leave through an output register.
// The sequencer steps one message per cycle and reuses one count incrementer/decrementer.
// After reset a clearing pass zeroes all CHANNELS*NOTES count entries with busy_o high.
// The receiver cannot stall: each result is shown for exactly one cycle.
//
// Top level of the MIDI output note and bank tracker.
// Depends on mont_pkg and mont_ram.
module midi_out_note_and_bank_tracker
  import mont_pkg::*;
#(
  parameter int CHANNELS  = 16,
  parameter int NOTES     = 128,
  parameter int COUNT_MAX = 63
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_t  req_i,
  output logic res_valid_o,
  output out_t res_o
);

  localparam int Depth = CHANNELS * NOTES;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PLAN  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  in_t              req_q;
  logic [AddrW-1:0] addr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             emit_msb_q, emit_msb_d;
  logic             emit_lsb_q, emit_lsb_d;
  logic             emit_prg_q, emit_prg_d;
  logic             upd_q, upd_d;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [6:0] last_lsb_q [BANK_DEPTH];
  logic [6:0] last_msb_q [BANK_DEPTH];
  logic [6:0] last_prg_q [BANK_DEPTH];

  logic                   accept;
  logic [ADDR_FULL_W-1:0] in_addr_full;
  logic [AddrW-1:0]       in_addr;
  logic [CH_W-1:0]        ch;
  logic                   ch_ok, note_ok, is_note, tracked, bank_chg, note_dec;
  logic                   plan_msb, plan_lsb, plan_prg;
  logic                   lsb_wr, msb_wr, prg_wr;
  logic [CNT_W-1:0]       rd_data, alu_res, upd_val;
  logic                   alu_dec, ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [CNT_W-1:0]       ram_wdata;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Count store address of the incoming transaction
  assign in_addr_full = ADDR_FULL_W'(req_i.status[3:0]) * ADDR_FULL_W'(NOTES)
                      + ADDR_FULL_W'(req_i.data_a);
  assign in_addr      = in_addr_full[AddrW-1:0];

  mont_ram #(
    .WIDTH (CNT_W),
    .DEPTH (Depth)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rd_data)
  );

  // Decode the held transaction
  assign ch       = req_q.status[3:0];
  assign ch_ok    = {1'b0, ch} < (CH_W + 1)'(CHANNELS);
  assign note_ok  = {1'b0, req_q.data_a} < 8'(NOTES);
  assign is_note  = (req_q.status[7:5] == 3'b100);
  assign tracked  = is_note && ch_ok;
  assign bank_chg = !req_q.bank_lsb[7]
                 && ((last_lsb_q[ch] != req_q.bank_lsb[6:0]) || req_q.bank_msb[7]
                     || (last_msb_q[ch] != req_q.bank_msb[6:0]));
  assign plan_msb = tracked && bank_chg && !req_q.bank_msb[7];
  assign plan_lsb = tracked && bank_chg;
  assign plan_prg = tracked && !req_q.program_req[7]
                 && (bank_chg || (last_prg_q[ch] != req_q.program_req[6:0]));
  assign note_dec = (req_q.status[7:4] == SN_NOTE_OFF) || (req_q.data_b == 7'd0);

  // Shared count unit: step by one up or down
  assign alu_dec = (state_q == ST_FLUSH) || note_dec;
  assign alu_res = alu_dec ? (cnt_q - CNT_W'(1)) : (cnt_q + CNT_W'(1));

  // Hold the count at zero or at the ceiling
  assign upd_val = ((note_dec && (cnt_q == '0))
                 || (!note_dec && (cnt_q >= CNT_W'(COUNT_MAX)))) ? cnt_q : alu_res;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    emit_msb_d  = emit_msb_q;
    emit_lsb_d  = emit_lsb_q;
    emit_prg_d  = emit_prg_q;
    upd_d       = upd_q;
    out_d       = out_q;
    out_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '0;
    lsb_wr      = 1'b0;
    msb_wr      = 1'b0;
    prg_wr      = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cnt_d = rd_data;
        if (req_q.func) begin
          if (ch_ok && note_ok && (rd_data != '0)) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (req_q.status[7:4] == SN_SYSTEM) begin
          state_d = ST_IDLE;
        end else begin
          emit_msb_d = plan_msb;
          emit_lsb_d = plan_lsb;
          emit_prg_d = plan_prg;
          upd_d      = tracked && note_ok;
          msb_wr     = plan_msb;
          lsb_wr     = plan_lsb;
          prg_wr     = plan_prg;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_d = 1'b1;
        out_d.last  = 1'b0;
        priority if (emit_msb_q) begin
          out_d.out_status = {SN_CTRL, ch};
          out_d.out_data_a = CC_BANK_MSB;
          out_d.out_data_b = req_q.bank_msb[6:0];
          emit_msb_d       = 1'b0;
        end else if (emit_lsb_q) begin
          out_d.out_status = {SN_CTRL, ch};
          out_d.out_data_a = CC_BANK_LSB;
          out_d.out_data_b = req_q.bank_lsb[6:0];
          emit_lsb_d       = 1'b0;
        end else if (emit_prg_q) begin
          out_d.out_status = {SN_PROG, ch};
          out_d.out_data_a = req_q.program_req[6:0];
          out_d.out_data_b = 7'd0;
          emit_prg_d       = 1'b0;
        end else begin
          out_d.out_status = req_q.status;
          out_d.out_data_a = req_q.data_a;
          out_d.out_data_b = req_q.data_b;
          out_d.last       = 1'b1;
          ram_we           = upd_q;
          ram_wdata        = upd_val;
          state_d          = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        out_valid_d      = 1'b1;
        out_d.out_status = {SN_NOTE_OFF, ch};
        out_d.out_data_a = req_q.data_a;
        out_d.out_data_b = 7'd0;
        out_d.last       = (cnt_q == CNT_W'(1));
        cnt_d            = alu_res;
        if (cnt_q == CNT_W'(1)) begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and per-channel bank and program tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      emit_msb_q  <= 1'b0;
      emit_lsb_q  <= 1'b0;
      emit_prg_q  <= 1'b0;
      upd_q       <= 1'b0;
      for (int i = 0; i < BANK_DEPTH; i++) begin
        last_lsb_q[i] <= '0;
        last_msb_q[i] <= '0;
        last_prg_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      emit_msb_q  <= emit_msb_d;
      emit_lsb_q  <= emit_lsb_d;
      emit_prg_q  <= emit_prg_d;
      upd_q       <= upd_d;
      if (msb_wr) begin
        last_msb_q[ch] <= req_q.bank_msb[6:0];
      end
      if (lsb_wr) begin
        last_lsb_q[ch] <= req_q.bank_lsb[6:0];
      end
      if (prg_wr) begin
        last_prg_q[ch] <= req_q.program_req[6:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i;
      addr_q <= in_addr;
    end
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

[design/mont_checker.sv]
// Port-level checker for the MIDI output note and bank tracker, bound to the top level.
// Depends on mont_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mont_checker
  import mont_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input in_t  req_i,
  input logic res_valid_o,
  input out_t res_o
);

  logic accept;

  assign accept = start_i && !busy_o;

  // A taken transaction keeps the block busy in the next cycle
  `MONT_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy_o, "idle right after accept")

  // Only the final message may show while the block is idle
  `MONT_ASSERT_NEVER(a_mid_idle, clk_i, rst_ni, res_valid_o && !res_o.last && !busy_o, "non-final result while idle")

  // Nothing follows the final message straight away
  `MONT_ASSERT(a_last_gap, clk_i, rst_ni, res_valid_o && res_o.last |=> !res_valid_o, "result right after final")

  // A system status send stays silent
  `MONT_ASSERT(a_sys_silent, clk_i, rst_ni, accept && !req_i.func && req_i.status[7:4] == SN_SYSTEM |=> !res_valid_o ##1 !res_valid_o, "result for system status")

endmodule

bind midi_out_note_and_bank_tracker mont_checker u_mont_checker (.*);

[test/tb.sv]
// Self-checking testbench for the MIDI output note and bank tracker.
// Depends on mont_pkg and midi_out_note_and_bank_tracker; predicts every emitted message.
`timescale 1ns / 100ps

module tb;
  import mont_pkg::*;

  localparam int         TOTAL_ITEMS = 480;
  localparam int         COUNT_LIMIT = 63;
  localparam int         TAIL_ITEMS  = 60;    // final items sent back to back
  localparam int         DRAIN_WAIT  = 100;   // cycles watched after the last message
  localparam int         MAX_REPORTS = 10;
  localparam logic [3:0] SN_NOTE_ON  = 4'h9;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  in_t  req_i   = '0;
  logic busy_o;
  logic res_valid_o;
  out_t res_o;

  // Request queue fed by the stimulus, with an optional idle gap after each request
  in_t  pending_reqs[$];
  int   pending_gaps[$];
  int   queued_cnt   = 0;
  int   accepted_cnt = 0;
  int   flush_cnt    = 0;
  int   gap_left     = 0;

  // Predicted MIDI messages, oldest first
  out_t expected_msgs[$];
  int   checked_cnt  = 0;
  int   mismatch_cnt = 0;

  // Predictor state: sounding notes and last bank and program per channel
  logic [5:0] held_count[16][128];
  logic [6:0] last_lsb[16];
  logic [6:0] last_msb[16];
  logic [6:0] last_prog[16];

  midi_out_note_and_bank_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    foreach (held_count[c, n]) held_count[c][n] = '0;
    foreach (last_lsb[c]) begin
      last_lsb[c]  = '0;
      last_msb[c]  = '0;
      last_prog[c] = '0;
    end
  end

  function automatic void queue_message(logic [7:0] st, logic [6:0] a, logic [6:0] b);
    out_t msg;
    msg = '{out_status: st, out_data_a: a, out_data_b: b, last: 1'b0};
    expected_msgs.insert(expected_msgs.size(), msg);
  endfunction

  // Work out the messages caused by one accepted request and update the state
  function automatic void predict_messages(input in_t item);
    logic [3:0] ch;
    logic       is_note;
    logic       send_prog;
    int         lsb_req;
    int         msb_req;
    int         prg_req;
    int         first;
    out_t       tail;
    ch      = item.status[3:0];
    lsb_req = $signed(item.bank_lsb);
    msb_req = $signed(item.bank_msb);
    prg_req = $signed(item.program_req);
    is_note = item.status[7:4] == SN_NOTE_OFF || item.status[7:4] == SN_NOTE_ON;
    first   = expected_msgs.size();
    if (item.func) begin
      for (int i = 0; i < held_count[ch][item.data_a]; i++)
        queue_message({SN_NOTE_OFF, ch}, item.data_a, 7'd0);
      held_count[ch][item.data_a] = '0;
    end else if (item.status[7:4] != SN_SYSTEM) begin
      if (is_note) begin
        send_prog = 1'b0;
        // A missing MSB counts as a bank change whenever an LSB is requested
        if (lsb_req >= 0 && (last_lsb[ch] != lsb_req[6:0] || msb_req < 0 ||
                             last_msb[ch] != msb_req[6:0])) begin
          if (msb_req >= 0) begin
            queue_message({SN_CTRL, ch}, CC_BANK_MSB, msb_req[6:0]);
            last_msb[ch] = msb_req[6:0];
          end
          queue_message({SN_CTRL, ch}, CC_BANK_LSB, lsb_req[6:0]);
          last_lsb[ch] = lsb_req[6:0];
          send_prog = prg_req >= 0;
        end else if (prg_req >= 0 && last_prog[ch] != prg_req[6:0]) begin
          send_prog = 1'b1;
        end
        if (send_prog) begin
          queue_message({SN_PROG, ch}, prg_req[6:0], 7'd0);
          last_prog[ch] = prg_req[6:0];
        end
      end
      queue_message(item.status, item.data_a, item.data_b);
      // Count sounding notes: note-off or zero velocity releases one
      if (is_note) begin
        if (item.status[7:4] == SN_NOTE_OFF || item.data_b == 7'd0) begin
          if (held_count[ch][item.data_a] != 0)
            held_count[ch][item.data_a] = held_count[ch][item.data_a] - 1'b1;
        end else if (held_count[ch][item.data_a] < COUNT_LIMIT) begin
          held_count[ch][item.data_a] = held_count[ch][item.data_a] + 1'b1;
        end
      end
    end
    // Mark the final message of this transaction
    if (expected_msgs.size() > first) begin
      tail      = expected_msgs.pop_back();
      tail.last = 1'b1;
      expected_msgs.insert(expected_msgs.size(), tail);
    end
  endfunction

  function automatic in_t make_req(logic f, logic [7:0] st, logic [6:0] a, logic [6:0] b,
                                   logic [7:0] lsb, logic [7:0] msb, logic [7:0] prg);
    in_t r;
    r = '{func: f, status: st, data_a: a, data_b: b,
          bank_lsb: lsb, bank_msb: msb, program_req: prg};
    return r;
  endfunction

  // Queue a request; idle gaps come in stretches and stop near the end
  task automatic queue_req(input in_t r);
    int gap;
    gap = 0;
    if (queued_cnt < TOTAL_ITEMS - TAIL_ITEMS && (queued_cnt % 90) < 60 &&
        $urandom_range(0, 2) == 0)
      gap = $urandom_range(1, 14);
    pending_reqs.insert(pending_reqs.size(), r);
    pending_gaps.insert(pending_gaps.size(), gap);
    queued_cnt++;
  endtask

  // Bank or program request: mostly none or a few repeating values
  function automatic logic [7:0] pick_bank_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return 8'hFF;
    if (sel == 3) return {1'b1, 7'($urandom)};
    if (sel < 8) return 8'($urandom_range(0, 2));
    if (sel == 8) return 8'd127;
    return {1'b0, 7'($urandom)};
  endfunction

  // Drive requests; hold start until the block takes the transaction
  always @(posedge clk_i or negedge rst_ni) begin : drv_blk
    logic nxt_start;
    in_t  nxt_req;
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i   <= '0;
    end else begin
      nxt_start = start_i;
      nxt_req   = req_i;
      if (start_i && !busy_o) begin
        predict_messages(req_i);
        accepted_cnt++;
        if (req_i.func) flush_cnt++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          nxt_req   = pending_reqs.pop_front();
          gap_left  = pending_gaps.pop_front();
          nxt_start = 1'b1;
        end
      end
      start_i <= nxt_start;
      req_i   <= nxt_req;
    end
  end

  // Compare each emitted message with the oldest prediction
  always @(posedge clk_i) begin : mon_blk
    out_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_msgs.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected message %h %h %h last=%b", $realtime,
                   res_o.out_status, res_o.out_data_a, res_o.out_data_b, res_o.last);
      end else begin
        want = expected_msgs.pop_front();
        checked_cnt++;
        if (res_o.out_status !== want.out_status || res_o.out_data_a !== want.out_data_a ||
            res_o.out_data_b !== want.out_data_b || res_o.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: expected %h %h %h last=%b, got %h %h %h last=%b", $realtime,
                     want.out_status, want.out_data_a, want.out_data_b, want.last,
                     res_o.out_status, res_o.out_data_a, res_o.out_data_b, res_o.last);
        end
      end
    end
  end

  // Stimulus, drain and verdict
  initial begin : stim_blk
    int         sel;
    logic [3:0] ch;
    logic [6:0] note;
    logic [6:0] notes_pool[4];
    notes_pool = '{7'd0, 7'd60, 7'd61, 7'd127};

    // Directed: bank and program sequencing, counts, system and non-note status
    queue_req(make_req(1'b0, 8'h90, 7'd60, 7'd100, 8'hFF, 8'hFF, 8'hFF));
    queue_req(make_req(1'b0, 8'h90, 7'd60, 7'd127, 8'd5, 8'd3, 8'd10));
    queue_req(make_req(1'b0, 8'h90, 7'd60, 7'd1, 8'd5, 8'd3, 8'd10));
    queue_req(make_req(1'b0, 8'h90, 7'd60, 7'd2, 8'd5, 8'hFF, 8'd10));
    queue_req(make_req(1'b0, 8'h81, 7'd127, 7'd0, 8'd127, 8'd127, 8'hFF));
    queue_req(make_req(1'b0, 8'h91, 7'd127, 7'd0, 8'd127, 8'd127, 8'd127));
    queue_req(make_req(1'b0, 8'h92, 7'd0, 7'd1, 8'h80, 8'hCE, 8'hFE));
    queue_req(make_req(1'b0, 8'h40, 7'd5, 7'd6, 8'd9, 8'd9, 8'd9));
    queue_req(make_req(1'b0, 8'hA3, 7'd127, 7'd127, 8'd1, 8'd1, 8'd1));
    queue_req(make_req(1'b0, 8'hEF, 7'd0, 7'd127, 8'hFF, 8'hFF, 8'hFF));
    queue_req(make_req(1'b0, 8'h00, 7'd127, 7'd0, 8'd0, 8'd0, 8'd0));
    queue_req(make_req(1'b0, 8'hF0, 7'd60, 7'd100, 8'd4, 8'd4, 8'd4));
    queue_req(make_req(1'b0, 8'hFF, 7'd127, 7'd127, 8'd127, 8'd127, 8'd127));
    queue_req(make_req(1'b1, 8'h05, 7'd10, 7'd0, 8'hFF, 8'hFF, 8'hFF));
    queue_req(make_req(1'b0, 8'h9F, 7'd127, 7'd127, 8'd0, 8'd0, 8'd0));
    queue_req(make_req(1'b0, 8'h9F, 7'd127, 7'd64, 8'd0, 8'd0, 8'd0));
    queue_req(make_req(1'b1, 8'hFF, 7'd127, 7'd127, 8'h80, 8'h80, 8'h80));
    queue_req(make_req(1'b1, 8'h30, 7'd60, 7'd0, 8'd0, 8'd0, 8'd0));
    queue_req(make_req(1'b0, 8'h80, 7'd60, 7'd64, 8'hFF, 8'hFF, 8'hFF));
    queue_req(make_req(1'b1, 8'h00, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    queue_req(make_req(1'b0, 8'hB2, 7'd0, 7'd127, 8'hFF, 8'd1, 8'd2));

    // Random: mostly note traffic on a small pool, with saturation bursts
    while (queued_cnt < TOTAL_ITEMS) begin
      sel  = $urandom_range(0, 99);
      ch   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      note = notes_pool[$urandom_range(0, 3)];
      if (queued_cnt == 40 || (sel < 2 && queued_cnt + 70 < TOTAL_ITEMS - TAIL_ITEMS)) begin
        // Saturate one count, then release it with a flush
        repeat (COUNT_LIMIT + 3)
          queue_req(make_req(1'b0, {SN_NOTE_ON, ch}, note, 7'($urandom_range(1, 127)),
                             8'hFF, 8'hFF, 8'hFF));
        queue_req(make_req(1'b1, {4'($urandom), ch}, note, 7'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (sel < 50) begin
        queue_req(make_req(1'b0,
                           {($urandom_range(0, 2) == 0) ? SN_NOTE_OFF : SN_NOTE_ON, ch},
                           note,
                           ($urandom_range(0, 5) == 0) ? 7'd0 : 7'($urandom),
                           pick_bank_value(), pick_bank_value(), pick_bank_value()));
      end else if (sel < 62) begin
        queue_req(make_req(1'b1, {4'($urandom), ch}, note, 7'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (sel < 70) begin
        queue_req(make_req(1'b0, 8'($urandom_range(0, 127)), 7'($urandom), 7'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (sel < 76) begin
        queue_req(make_req(1'b0, 8'($urandom_range(8'hA0, 8'hEF)), 7'($urandom),
                           7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (sel < 80) begin
        queue_req(make_req(1'b0, 8'($urandom_range(8'hF0, 8'hFF)), 7'($urandom),
                           7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (sel < 88) begin
        queue_req(make_req(1'($urandom), 8'($urandom), 7'($urandom), 7'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom)));
      end else begin
        queue_req(make_req(1'b0, {1'b1, 3'b00, 1'($urandom), ch}, 7'($urandom),
                           7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      end
    end

    // Release reset, then wait for every transaction and every message
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (accepted_cnt < queued_cnt) @(posedge clk_i);
    while (expected_msgs.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run covered %0d transactions (%0d flushes) and %0d checked MIDI messages.",
             accepted_cnt, flush_cnt, checked_cnt);
    $display("Messages in error: %0d", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard limit on the run length
  initial begin
    #2_000_000;
    $display("Timed out with %0d messages still expected", expected_msgs.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
